FILE: src/ringtone_record_checker_assert.svh
// Assertion macros for the ringtone record checker.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef RINGTONE_RECORD_CHECKER_ASSERT_SVH
`define RINGTONE_RECORD_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RRC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rrc_pkg.sv
// Shared types and constants for the ringtone record checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rrc_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_SEPARATOR    = 4'd1,
        ST_NO_HASH      = 4'd2,
        ST_BAD_DIGIT    = 4'd3,
        ST_NAME         = 4'd4,
        ST_TEMPO        = 4'd5,
        ST_ARTICULATION = 4'd6,
        ST_NO_NOTES     = 4'd7,
        ST_NOTE         = 4'd8,
        ST_LENGTH       = 4'd9,
        ST_OVERFLOW     = 4'd10
    } status_t;

    // Tempo codes
    localparam logic [2:0] TEMPO_ADG = 3'd0;
    localparam logic [2:0] TEMPO_AND = 3'd1;
    localparam logic [2:0] TEMPO_MDR = 3'd2;
    localparam logic [2:0] TEMPO_ALL = 3'd3;
    localparam logic [2:0] TEMPO_PRS = 3'd4;

    // Special characters
    localparam logic [7:0] CH_SEPARATOR = 8'h3B;
    localparam logic [7:0] CH_END_MARK  = 8'hFF;
    localparam logic [7:0] CH_HASH      = 8'h23;

    // Character ranges (DIGIT and NAME bounds exclusive, NOTE_MAX and LEN_MAX inclusive)
    localparam logic [7:0] DIGIT_LO = 8'd47;
    localparam logic [7:0] DIGIT_HI = 8'd58;
    localparam logic [7:0] ZERO_CH  = 8'd48;
    localparam logic [7:0] NAME_LO  = 8'd33;
    localparam logic [7:0] NAME_HI  = 8'd126;
    localparam logic [7:0] NOTE_MAX = 8'd32;
    localparam logic [7:0] LEN_MAX  = 8'd6;

    // Header layout
    localparam int P_HASH    = 0;
    localparam int P_DIGIT   = 1;
    localparam int P_SEP0    = 2;
    localparam int P_NAME0   = 3;
    localparam int P_NAME7   = 10;
    localparam int P_SEP1    = 11;
    localparam int P_TEMPO0  = 12;
    localparam int P_TEMPO1  = 13;
    localparam int P_TEMPO2  = 14;
    localparam int P_SEP2    = 15;
    localparam int P_ART0    = 16;
    localparam int P_ART1    = 17;
    localparam int P_SEP3    = 18;
    localparam int P_NOTES   = 19;

    // Check flag bit positions
    localparam int F_SEP   = 0;
    localparam int F_HASH  = 1;
    localparam int F_DIGIT = 2;
    localparam int F_NAME  = 3;
    localparam int F_TEMPO = 4;
    localparam int F_ART   = 5;
    localparam int F_NOTE  = 6;
    localparam int F_LEN   = 7;
    localparam int NUM_FLAGS = 8;

    // One result item
    typedef struct packed {
        status_t    status;
        logic [3:0] slot;
        logic [2:0] tempo;
        logic       staccato;
        logic [5:0] end_position;
    } result_t;

endpackage

FILE: src/ringtone_record_checker.sv
// Top level of the ringtone record checker.
// Depends on rrc_pkg, rrc_in_stage, rrc_checker and rrc_out_stage.
//
//  Channel | Signals                                      | Flow
//  --------+----------------------------------------------+----------------------
//  input   | rx_byte, in_valid, in_stall                  | one byte per transfer
//  output  | status, slot, tempo, staccato, end_position, | one result per record
//          | out_valid, out_stall                         |
//
// One byte per cycle sustained while no output stall holds the input.
// A record's last byte crosses the input register, check logic and the result register.
// Reset clears the position, check flags, header state and both valid bits.
// An output stall holds bytes only when the waiting byte ends or overflows a record.
// A record of MAX_LEN bytes without end marker yields an overflow result on the next byte.
`timescale 1ns / 1ps

module ringtone_record_checker
    import rrc_pkg::*;
#(
    parameter int MAX_LEN = 60
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] status,
    output logic [3:0] slot,
    output logic [2:0] tempo,
    output logic       staccato,
    output logic [5:0] end_position
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       has_result;
    logic       out_free;
    logic       fire;
    result_t    res;
    result_t    res_out;

    // Byte is processed unless its result finds the output register full and stalled
    assign fire = item_valid && (!has_result || out_free);

    rrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .in_stall   (in_stall),
        .fire       (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    rrc_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .fire       (fire),
        .has_result (has_result),
        .res        (res)
    );

    rrc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && has_result),
        .res_in    (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status       = res_out.status;
    assign slot         = res_out.slot;
    assign tempo        = res_out.tempo;
    assign staccato     = res_out.staccato;
    assign end_position = res_out.end_position;

endmodule

FILE: src/rrc_in_stage.sv
// Input register of the ringtone record checker.
// Depends on rrc_pkg; holds one received byte until the checker takes it.
`timescale 1ns / 1ps

module rrc_in_stage
    import rrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    output logic       in_stall,
    input  logic       fire,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Stage holds while its byte waits for the checker
    assign in_stall   = valid_reg && !fire;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte register, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

FILE: src/rrc_checker.sv
// Position tracking, per-byte checks and status selection.
// Depends on rrc_pkg and ringtone_record_checker_assert.svh.
`timescale 1ns / 1ps

`include "ringtone_record_checker_assert.svh"

module rrc_checker
    import rrc_pkg::*;
#(
    parameter int MAX_LEN = 60
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       fire,
    output logic       has_result,
    output result_t    res
);

    localparam int POS_W = ($clog2(MAX_LEN + 1) < 6) ? 6 : $clog2(MAX_LEN + 1);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [NUM_FLAGS-1:0] flags_reg, flags_next;
    logic [7:0]           held0_reg, held0_next;
    logic [7:0]           held1_reg, held1_next;
    logic [3:0]           slot_reg, slot_next;
    logic [2:0]           tempo_reg, tempo_next;
    logic                 stacc_reg, stacc_next;

    logic                 overflow;
    logic                 is_end;
    logic                 len_at_end;
    status_t              status_sel;

    assign overflow   = pos_reg >= POS_W'(MAX_LEN);
    assign is_end     = item_byte == CH_END_MARK;
    assign has_result = item_valid && (overflow || is_end);

    // Byte check against its position
    always_comb
    begin
        pos_next   = pos_reg + POS_W'(1);
        flags_next = flags_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        slot_next  = slot_reg;
        tempo_next = tempo_reg;
        stacc_next = stacc_reg;
        case (pos_reg)
            POS_W'(P_HASH):
            begin
                if (item_byte != CH_HASH) flags_next[F_HASH] = 1'b1;
            end
            POS_W'(P_DIGIT):
            begin
                if (item_byte > DIGIT_LO && item_byte < DIGIT_HI)
                    slot_next = 4'(item_byte - ZERO_CH);
                else
                    flags_next[F_DIGIT] = 1'b1;
            end
            POS_W'(P_SEP0), POS_W'(P_SEP1), POS_W'(P_SEP2), POS_W'(P_SEP3):
            begin
                if (item_byte != CH_SEPARATOR) flags_next[F_SEP] = 1'b1;
            end
            POS_W'(P_NAME0), POS_W'(P_NAME0 + 1), POS_W'(P_NAME0 + 2),
            POS_W'(P_NAME0 + 3), POS_W'(P_NAME0 + 4), POS_W'(P_NAME0 + 5),
            POS_W'(P_NAME0 + 6), POS_W'(P_NAME7):
            begin
                if (!(item_byte > NAME_LO && item_byte < NAME_HI))
                    flags_next[F_NAME] = 1'b1;
            end
            POS_W'(P_TEMPO0), POS_W'(P_ART0):
            begin
                held0_next = item_byte;
            end
            POS_W'(P_TEMPO1):
            begin
                held1_next = item_byte;
            end
            POS_W'(P_TEMPO2):
            begin
                if (held0_reg == "A" && held1_reg == "D" && item_byte == "G")
                    tempo_next = TEMPO_ADG;
                else if (held0_reg == "A" && held1_reg == "N" && item_byte == "D")
                    tempo_next = TEMPO_AND;
                else if (held0_reg == "M" && held1_reg == "D" && item_byte == "R")
                    tempo_next = TEMPO_MDR;
                else if (held0_reg == "A" && held1_reg == "L" && item_byte == "L")
                    tempo_next = TEMPO_ALL;
                else if (held0_reg == "P" && held1_reg == "R" && item_byte == "S")
                    tempo_next = TEMPO_PRS;
                else
                    flags_next[F_TEMPO] = 1'b1;
            end
            POS_W'(P_ART1):
            begin
                if (held0_reg == "L" && item_byte == "G")
                    stacc_next = 1'b0;
                else if (held0_reg == "S" && item_byte == "T")
                    stacc_next = 1'b1;
                else
                    flags_next[F_ART] = 1'b1;
            end
            default:
            begin
                // Note area: odd positions hold notes, even ones lengths
                if (!flags_reg[F_NOTE] && !flags_reg[F_LEN])
                begin
                    if (pos_reg[0])
                    begin
                        if (item_byte > NOTE_MAX) flags_next[F_NOTE] = 1'b1;
                    end
                    else
                    begin
                        if (item_byte > LEN_MAX) flags_next[F_LEN] = 1'b1;
                    end
                end
            end
        endcase
        // End marker or overflow starts a new record
        if (has_result)
        begin
            pos_next   = '0;
            flags_next = '0;
            held0_next = '0;
            held1_next = '0;
            slot_next  = '0;
            tempo_next = '0;
            stacc_next = 1'b0;
        end
    end

    // End marker in place of a length byte fails that length
    assign len_at_end = !pos_reg[0] && !flags_reg[F_NOTE] && !flags_reg[F_LEN];

    // Overflow, separator, then header order; early end leaves a separator missing
    always_comb
    begin
        if (overflow)                          status_sel = ST_OVERFLOW;
        else if (pos_reg < POS_W'(P_NOTES))    status_sel = ST_SEPARATOR;
        else if (flags_reg[F_SEP])             status_sel = ST_SEPARATOR;
        else if (flags_reg[F_HASH])            status_sel = ST_NO_HASH;
        else if (flags_reg[F_DIGIT])           status_sel = ST_BAD_DIGIT;
        else if (flags_reg[F_NAME])            status_sel = ST_NAME;
        else if (flags_reg[F_TEMPO])           status_sel = ST_TEMPO;
        else if (flags_reg[F_ART])             status_sel = ST_ARTICULATION;
        else if (pos_reg == POS_W'(P_NOTES))   status_sel = ST_NO_NOTES;
        else if (flags_reg[F_NOTE])            status_sel = ST_NOTE;
        else if (flags_reg[F_LEN] || len_at_end) status_sel = ST_LENGTH;
        else                                   status_sel = ST_OK;
    end

    // Result fields
    always_comb
    begin
        res.status       = status_sel;
        res.slot         = (status_sel == ST_OK) ? slot_reg : 4'd0;
        res.tempo        = (status_sel == ST_OK) ? tempo_reg : 3'd0;
        res.staccato     = (status_sel == ST_OK) ? stacc_reg : 1'b0;
        res.end_position = overflow ? 6'd0 : pos_reg[5:0];
    end

    // Record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
            slot_reg  <= '0;
            tempo_reg <= '0;
            stacc_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            slot_reg  <= slot_next;
            tempo_reg <= tempo_next;
            stacc_reg <= stacc_next;
        end
    end

    // Checks
    `RRC_ASSERT_IMPLIES(a_pos_bound, 1'b1, pos_reg <= POS_W'(MAX_LEN), "position beyond limit")
    `RRC_ASSERT_NEXT(a_restart, fire && has_result, pos_reg == '0, "no restart after result")
    `RRC_ASSERT_NEXT(a_advance, fire && !has_result,
                     pos_reg == $past(pos_reg) + POS_W'(1), "position did not advance")
    `RRC_ASSERT_IMPLIES(a_ok_fields, has_result && res.status == ST_OK,
                        res.slot <= 4'd9 && res.tempo <= TEMPO_PRS, "bad fields with ok status")

endmodule

FILE: src/rrc_out_stage.sv
// Result register of the ringtone record checker.
// Depends on rrc_pkg; holds one result until the receiving side takes it.
`timescale 1ns / 1ps

module rrc_out_stage
    import rrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    output logic    free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Register may take a new result once empty or being drained
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)           valid_next = 1'b1;
        else if (out_stall) valid_next = valid_reg;
        else                valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ringtone record checker.
// Depends on rrc_pkg and ringtone_record_checker; drives records byte by byte
// and checks every end-of-record report against a predictor of its own.
`timescale 1ns / 1ps

module testbench;
    import rrc_pkg::*;

    localparam int REC_MAX_LEN    = 60;
    localparam int RANDOM_BYTES   = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int NUM_DIRECTED   = 25;

    // Record shapes for the random part
    localparam int REC_GOOD       = 0;
    localparam int REC_BAD_HEADER = 1;
    localparam int REC_BAD_NOTES  = 2;
    localparam int REC_ODD_END    = 3;
    localparam int REC_SHORT      = 4;
    localparam int REC_OVERFLOW   = 5;
    localparam int REC_NOISE      = 6;
    localparam int REC_FULL       = 7;
    localparam int NUM_REC_KINDS  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        result_t    report;
    } directed_row_t;

    // Lone end marker, then a full record with extreme field values
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{8'hFF, 1'b1, '{ST_SEPARATOR, 4'd0, 3'd0, 1'b0, 6'd0}},
        '{"#",   1'b0, '0},
        '{"9",   1'b0, '0},
        '{";",   1'b0, '0},
        '{8'd34, 1'b0, '0},
        '{8'd125, 1'b0, '0},
        '{"R",   1'b0, '0},
        '{"i",   1'b0, '0},
        '{"n",   1'b0, '0},
        '{"g",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"}",   1'b0, '0},
        '{";",   1'b0, '0},
        '{"P",   1'b0, '0},
        '{"R",   1'b0, '0},
        '{"S",   1'b0, '0},
        '{";",   1'b0, '0},
        '{"S",   1'b0, '0},
        '{"T",   1'b0, '0},
        '{";",   1'b0, '0},
        '{8'd32, 1'b0, '0},
        '{8'd6,  1'b0, '0},
        '{8'd0,  1'b0, '0},
        '{8'd0,  1'b0, '0},
        '{8'hFF, 1'b1, '{ST_OK, 4'd9, TEMPO_PRS, 1'b1, 6'd23}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] status;
    logic [3:0] slot;
    logic [2:0] tempo;
    logic       staccato;
    logic [5:0] end_position;

    // Predictor state
    int unsigned rec_pos;
    logic [8:0]  rec_flags;
    logic [7:0]  hdr_chars [3];
    logic [3:0]  hdr_slot;
    logic [2:0]  hdr_tempo;
    logic        hdr_staccato;

    result_t     pending_reports [$];
    logic [7:0]  rec_q [$];
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    bit          gappy = 1'b1;

    ringtone_record_checker #(.MAX_LEN(REC_MAX_LEN)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .tempo        (tempo),
        .staccato     (staccato),
        .end_position (end_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_record();
        rec_pos      = 0;
        rec_flags    = '0;
        hdr_chars[0] = 8'd0;
        hdr_chars[1] = 8'd0;
        hdr_chars[2] = 8'd0;
        hdr_slot     = 4'd0;
        hdr_tempo    = TEMPO_ADG;
        hdr_staccato = 1'b0;
    endfunction

    // Check one byte against what its position allows; failures latch
    function automatic void check_byte_at(int unsigned pos, logic [7:0] v);
        if (pos == P_HASH)
        begin
            if (v != CH_HASH) rec_flags[F_HASH] = 1'b1;
        end
        else if (pos == P_DIGIT)
        begin
            if (v > DIGIT_LO && v < DIGIT_HI) hdr_slot = 4'(v - ZERO_CH);
            else rec_flags[F_DIGIT] = 1'b1;
        end
        else if (pos == P_SEP0 || pos == P_SEP1 || pos == P_SEP2 || pos == P_SEP3)
        begin
            if (v != CH_SEPARATOR) rec_flags[F_SEP] = 1'b1;
        end
        else if (pos >= P_NAME0 && pos <= P_NAME7)
        begin
            if (!(v > NAME_LO && v < NAME_HI)) rec_flags[F_NAME] = 1'b1;
        end
        else if (pos == P_TEMPO0) hdr_chars[0] = v;
        else if (pos == P_TEMPO1) hdr_chars[1] = v;
        else if (pos == P_TEMPO2)
        begin
            hdr_chars[2] = v;
            case ({hdr_chars[0], hdr_chars[1], v})
                "ADG":   hdr_tempo = TEMPO_ADG;
                "AND":   hdr_tempo = TEMPO_AND;
                "MDR":   hdr_tempo = TEMPO_MDR;
                "ALL":   hdr_tempo = TEMPO_ALL;
                "PRS":   hdr_tempo = TEMPO_PRS;
                default: rec_flags[F_TEMPO] = 1'b1;
            endcase
        end
        else if (pos == P_ART0) hdr_chars[0] = v;
        else if (pos == P_ART1)
        begin
            case ({hdr_chars[0], v})
                "LG":    hdr_staccato = 1'b0;
                "ST":    hdr_staccato = 1'b1;
                default: rec_flags[F_ART] = 1'b1;
            endcase
        end
        // note area: only the first bad byte counts
        else if (!rec_flags[F_NOTE] && !rec_flags[F_LEN])
        begin
            if (((pos - P_NOTES) & 1) == 0)
            begin
                if (v > NOTE_MAX) rec_flags[F_NOTE] = 1'b1;
            end
            else if (v > LEN_MAX) rec_flags[F_LEN] = 1'b1;
        end
    endfunction

    // Advance the predictor by one byte; returns 1 when a report is due
    function automatic bit predict_report(logic [7:0] v, output result_t rep);
        int unsigned p;
        status_t st;
        p   = rec_pos;
        rep = '0;
        if (p >= REC_MAX_LEN)
        begin
            clear_record();
            rep.status = ST_OVERFLOW;
            return 1'b1;
        end
        if (v != CH_END_MARK)
        begin
            check_byte_at(p, v);
            rec_pos = p + 1;
            return 1'b0;
        end
        // missing header bytes read as zero, the marker itself as 0xFF
        if (p < P_NOTES)
        begin
            for (int unsigned q = p; q < P_NOTES; q++)
                check_byte_at(q, (q == p) ? CH_END_MARK : 8'd0);
        end
        else if (((p - P_NOTES) & 1) != 0)
            check_byte_at(p, CH_END_MARK);

        if (rec_flags[F_SEP])        st = ST_SEPARATOR;
        else if (rec_flags[F_HASH])  st = ST_NO_HASH;
        else if (rec_flags[F_DIGIT]) st = ST_BAD_DIGIT;
        else if (rec_flags[F_NAME])  st = ST_NAME;
        else if (rec_flags[F_TEMPO]) st = ST_TEMPO;
        else if (rec_flags[F_ART])   st = ST_ARTICULATION;
        else if (p == P_NOTES)       st = ST_NO_NOTES;
        else if (rec_flags[F_NOTE])  st = ST_NOTE;
        else if (rec_flags[F_LEN])   st = ST_LENGTH;
        else                         st = ST_OK;

        rep.status       = st;
        rep.slot         = (st == ST_OK) ? hdr_slot : 4'd0;
        rep.tempo        = (st == ST_OK) ? hdr_tempo : 3'd0;
        rep.staccato     = (st == ST_OK) ? hdr_staccato : 1'b0;
        rep.end_position = 6'(p);
        clear_record();
        return 1'b1;
    endfunction

    // Record builders
    function automatic logic [23:0] tempo_text(logic [2:0] code);
        case (code)
            TEMPO_ADG: return "ADG";
            TEMPO_AND: return "AND";
            TEMPO_MDR: return "MDR";
            TEMPO_ALL: return "ALL";
            default:   return "PRS";
        endcase
    endfunction

    function automatic void add_header();
        logic [23:0] tw;
        logic [15:0] aw;
        tw = tempo_text(3'($urandom_range(0, 4)));
        aw = ($urandom_range(0, 1) != 0) ? "ST" : "LG";
        rec_q.push_back(CH_HASH);
        rec_q.push_back(ZERO_CH + 8'($urandom_range(0, 9)));
        rec_q.push_back(CH_SEPARATOR);
        repeat (8) rec_q.push_back(8'($urandom_range(NAME_LO + 1, NAME_HI - 1)));
        rec_q.push_back(CH_SEPARATOR);
        rec_q.push_back(tw[23:16]);
        rec_q.push_back(tw[15:8]);
        rec_q.push_back(tw[7:0]);
        rec_q.push_back(CH_SEPARATOR);
        rec_q.push_back(aw[15:8]);
        rec_q.push_back(aw[7:0]);
        rec_q.push_back(CH_SEPARATOR);
    endfunction

    function automatic void add_pairs(int unsigned n);
        repeat (n)
        begin
            rec_q.push_back(8'($urandom_range(0, NOTE_MAX)));
            rec_q.push_back(8'($urandom_range(0, LEN_MAX)));
        end
    endfunction

    // Header corruption, mostly just outside a range boundary
    function automatic logic [7:0] near_miss();
        case ($urandom_range(0, 5))
            0:       return NAME_LO;
            1:       return DIGIT_LO;
            2:       return DIGIT_HI;
            3:       return NAME_HI;
            4:       return 8'($urandom_range(65, 90));  // upper-case letter
            default: return 8'($urandom_range(0, 254));
        endcase
    endfunction

    function automatic logic [7:0] bad_note_byte();
        case ($urandom_range(0, 2))
            0:       return NOTE_MAX + 8'd1;
            1:       return LEN_MAX + 8'd1;
            default: return 8'($urandom_range(0, 254));
        endcase
    endfunction

    function automatic int unsigned pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)      return REC_GOOD;
        else if (r < 50) return REC_BAD_HEADER;
        else if (r < 65) return REC_BAD_NOTES;
        else if (r < 75) return REC_ODD_END;
        else if (r < 85) return REC_SHORT;
        else if (r < 90) return REC_OVERFLOW;
        else if (r < 95) return REC_NOISE;
        else             return REC_FULL;
    endfunction

    function automatic void build_record(int unsigned kind);
        int unsigned cut;
        rec_q.delete();
        case (kind)
            REC_GOOD:
            begin
                add_header();
                add_pairs($urandom_range(0, 8));
            end
            REC_BAD_HEADER:
            begin
                add_header();
                add_pairs($urandom_range(1, 6));
                rec_q[$urandom_range(P_HASH, P_SEP3)] = near_miss();
            end
            REC_BAD_NOTES:
            begin
                add_header();
                add_pairs($urandom_range(1, 8));
                repeat ($urandom_range(1, 2))
                    rec_q[$urandom_range(P_NOTES, rec_q.size() - 1)] = bad_note_byte();
            end
            REC_ODD_END:
            begin
                // end marker lands where a length belongs
                add_header();
                add_pairs($urandom_range(0, 6));
                rec_q.push_back(8'($urandom_range(0, NOTE_MAX)));
            end
            REC_SHORT:
            begin
                add_header();
                cut = $urandom_range(0, P_SEP3);
                while (rec_q.size() > cut) void'(rec_q.pop_back());
            end
            REC_OVERFLOW:
            begin
                // MAX_LEN bytes without a marker, then one byte that is dropped
                add_header();
                add_pairs(20);
                rec_q.push_back(8'($urandom_range(0, NOTE_MAX)));
                rec_q.push_back(8'($urandom_range(0, 255)));
                return;
            end
            REC_NOISE:
            begin
                repeat ($urandom_range(1, 40))
                    rec_q.push_back(($urandom_range(0, 7) == 0) ? CH_END_MARK
                                                                : 8'($urandom_range(0, 255)));
                return;
            end
            default:
            begin
                // longest record that still fits
                add_header();
                add_pairs(20);
            end
        endcase
        rec_q.push_back(CH_END_MARK);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gappy) return 0;
        r = $urandom_range(0, 99);
        if (r < 60)      return 0;
        else if (r < 95) return $urandom_range(1, 3);
        else             return $urandom_range(8, 30);
    endfunction

    // Send one byte; called and returning at a rising edge
    task automatic push_byte(input logic [7:0] b, input bit typed, input result_t typed_rep);
        int unsigned gap;
        result_t rep;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (predict_report(b, rep))
            pending_reports.push_back(typed ? typed_rep : rep);
    endtask

    // Hold the sender until every expected report has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
    endtask

    // Output stall: bursts of random length with calm stretches between
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (calm_left > 0)
        begin
            out_stall <= 1'b0;
            calm_left--;
        end
        else if ($urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 3);
        else
            calm_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 8);
    end

    // Report checker
    always @(posedge clk)
    begin : report_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with none expected (status %0d)", $time, status);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                    mismatches++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t: slot expected %0d, got %0d", $time, want.slot, slot);
                    mismatches++;
                end
                if (tempo !== want.tempo)
                begin
                    $display("%0t: tempo expected %0d, got %0d", $time, want.tempo, tempo);
                    mismatches++;
                end
                if (staccato !== want.staccato)
                begin
                    $display("%0t: staccato expected %0d, got %0d", $time, want.staccato,
                             staccato);
                    mismatches++;
                end
                if (end_position !== want.end_position)
                begin
                    $display("%0t: end_position expected %0d, got %0d", $time,
                             want.end_position, end_position);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned rec_idx;
        int unsigned kind;
        clear_record();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < NUM_DIRECTED; i++)
            push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].report);
        wait_drained();

        // random records: each shape once, then weighted
        rec_idx = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            kind = (rec_idx < NUM_REC_KINDS) ? rec_idx : pick_kind();
            build_record(kind);
            gappy = ($urandom_range(0, 2) != 0);
            foreach (rec_q[i]) push_byte(rec_q[i], 1'b0, '0);
            if ($urandom_range(0, 19) == 0) wait_drained();
            rec_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
